FILE: hw/rtl/fpfc_pkg.sv
`default_nettype none

package fpfc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SHOOT_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_MODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PUSHER_RATE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_COUNT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLYWHEEL_SPEED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CACHE_DELAY    = 3'd5;

  localparam logic [7:0] FULL_AUTO_SHOTS  = 8'd3;
  localparam logic [7:0] CACHE_SHOTS_MAX  = 8'd255;
  localparam logic [7:0] BURST_COUNT_RST  = 8'd1;

  typedef enum logic [1:0] {
    SHOOT_NULL      = 2'd0,
    SHOOT_FULL_AUTO = 2'd1,
    SHOOT_SELECT    = 2'd2,
    SHOOT_CACHE     = 2'd3
  } fire_sel_t;

  typedef enum logic [1:0] {
    TRIG_NULL   = 2'd0,
    TRIG_COMMIT = 2'd1,
    TRIG_PRESS  = 2'd2,
    TRIG_SPARE  = 2'd3
  } trig_sel_t;

  typedef struct packed {
    fire_sel_t   fire_sel;
    trig_sel_t   trig_sel;
    logic [15:0] push_rate;
    logic [7:0]  burst_len;
    logic [15:0] wheel_target;
    logic [15:0] hold_ms;
  } fpfc_cfg_t;

  typedef struct packed {
    logic        trigger_level;
    logic        trigger_rose;
    logic        trigger_fell;
    logic        trigger_toggled;
    logic        wheel_at_speed;
    logic        pusher_busy;
    logic [31:0] now_ms;
  } fpfc_in_t;

  typedef struct packed {
    logic        push_cmd;
    logic [15:0] push_rate_out;
    logic [7:0]  push_shots;
    logic        halt_cmd;
    logic        speed_cmd;
    logic [15:0] speed_out;
  } fpfc_out_t;

  typedef struct packed {
    logic        fire_request;
    logic        request_changed;
    logic        pushing_started;
    logic        cycle_done;
    logic        collecting;
    logic [31:0] window_start;
    logic [7:0]  collected_shots;
  } fpfc_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fpfc_step.sv
`default_nettype none

module fpfc_step
  import fpfc_pkg::*;
(
  input  wire fpfc_cfg_t   cfg,
  input  wire fpfc_state_t st,
  input  wire fpfc_in_t    item,
  output fpfc_state_t      st_nxt,
  output fpfc_out_t        res
);

  logic [31:0] elapsed;
  logic        expired;

  assign elapsed = item.now_ms - st.window_start;
  assign expired = elapsed > {16'd0, cfg.hold_ms};

  always_comb begin
    fpfc_state_t s;
    fpfc_out_t   r;
    s = st;
    r = '0;

    if (cfg.fire_sel != SHOOT_CACHE) begin
      s.collecting = 1'b0;
    end

    // trigger request tracking, shared by full auto and select fire
    if (cfg.fire_sel inside {SHOOT_FULL_AUTO, SHOOT_SELECT}) begin
      case (cfg.trig_sel)
        TRIG_COMMIT: begin
          s.fire_request    = item.trigger_level;
          s.request_changed = item.trigger_toggled;
        end
        TRIG_PRESS: begin
          if (item.trigger_rose) begin
            s.fire_request    = 1'b1;
            s.request_changed = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    case (cfg.fire_sel)
      SHOOT_FULL_AUTO: begin
        if (item.trigger_rose) begin
          r.push_cmd      = 1'b1;
          r.push_rate_out = cfg.push_rate;
          r.push_shots    = FULL_AUTO_SHOTS;
        end
        r.halt_cmd = item.trigger_fell;
      end
      SHOOT_SELECT: begin
        if (s.fire_request) begin
          if (s.request_changed) begin
            s.request_changed = 1'b0;
            r.speed_cmd       = 1'b1;
            r.speed_out       = cfg.wheel_target;
          end else if (item.wheel_at_speed && !item.pusher_busy && !s.pushing_started) begin
            r.push_cmd        = 1'b1;
            r.push_rate_out   = cfg.push_rate;
            r.push_shots      = cfg.burst_len;
            s.pushing_started = 1'b1;
          end else if (!item.pusher_busy && s.pushing_started && !s.cycle_done) begin
            r.speed_cmd       = 1'b1;
            s.fire_request    = 1'b0;
            s.request_changed = 1'b1;
            s.cycle_done      = 1'b1;
          end
        end else if (s.request_changed) begin
          r.halt_cmd        = 1'b1;
          r.speed_cmd       = 1'b1;
          s.pushing_started = 1'b0;
          s.fire_request    = 1'b0;
          s.request_changed = 1'b0;
          s.cycle_done      = 1'b0;
        end
      end
      SHOOT_CACHE: begin
        if (s.collecting && expired) begin
          if (item.wheel_at_speed && !item.pusher_busy) begin
            if (!s.pushing_started) begin
              r.push_cmd        = 1'b1;
              r.push_rate_out   = cfg.push_rate;
              r.push_shots      = s.collected_shots;
              s.pushing_started = 1'b1;
            end else begin
              s.collecting      = 1'b0;
              s.pushing_started = 1'b0;
            end
          end
        end else if (item.trigger_rose) begin
          if (s.collecting) begin
            if (s.collected_shots != CACHE_SHOTS_MAX) begin
              s.collected_shots = s.collected_shots + 8'd1;
            end
          end else begin
            s.window_start    = item.now_ms;
            r.speed_cmd       = 1'b1;
            r.speed_out       = cfg.wheel_target;
            s.collected_shots = 8'd1;
            s.collecting      = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    st_nxt = s;
    res    = r;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/flywheel_pusher_fire_control.sv
`default_nettype none

// Fire-control sequencer for a flywheel-and-pusher launcher. Each input
// transaction is one control tick; it yields exactly one command transaction.
// A tick is taken in every cycle the command register is free or being
// drained, so throughput is one tick per clock, and its command appears in
// the output register in the cycle after acceptance. The clock-setting path
// is the 32-bit wrapping subtract and compare of the cache window. Unused
// indexes are ignored; the user must write configuration registers through
// cfg_we/cfg_index/cfg_wdata only while no tick is in flight (not enforced).

module flywheel_pusher_fire_control
  import fpfc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire fpfc_in_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output fpfc_out_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  fpfc_cfg_t   cfg_r;
  fpfc_state_t state_r;
  fpfc_state_t state_nxt;
  fpfc_out_t   res_nxt;
  fpfc_out_t   out_data_r;
  logic        out_valid_r;
  logic        in_accept;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  fpfc_step u_step (
    .cfg    (cfg_r),
    .st     (state_r),
    .item   (in_data),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fire_sel     <= SHOOT_NULL;
      cfg_r.trig_sel     <= TRIG_NULL;
      cfg_r.push_rate    <= '0;
      cfg_r.burst_len    <= BURST_COUNT_RST;
      cfg_r.wheel_target <= '0;
      cfg_r.hold_ms      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHOOT_MODE:     cfg_r.fire_sel     <= fire_sel_t'(cfg_wdata[1:0]);
        REG_TRIGGER_MODE:   cfg_r.trig_sel     <= trig_sel_t'(cfg_wdata[1:0]);
        REG_PUSHER_RATE:    cfg_r.push_rate    <= cfg_wdata;
        REG_BURST_COUNT:    cfg_r.burst_len    <= cfg_wdata[7:0];
        REG_FLYWHEEL_SPEED: cfg_r.wheel_target <= cfg_wdata;
        REG_CACHE_DELAY:    cfg_r.hold_ms      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        state_r <= state_nxt;
      end
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // command payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fpfc_checker.sv
`default_nettype none

module fpfc_checker
  import fpfc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire fpfc_out_t out_data
);

  // a stalled command transaction stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled command transaction dropped or changed");

  // input only backs up behind a held command
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a pending command");

  // every accepted tick lands in the command register
  a_tick_to_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted tick produced no command");

  a_push_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.push_cmd |->
      out_data.push_rate_out == 16'd0 && out_data.push_shots == 8'd0)
    else $error("push fields nonzero without push command");

  a_speed_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.speed_cmd |-> out_data.speed_out == 16'd0)
    else $error("speed field nonzero without speed command");

endmodule

bind flywheel_pusher_fire_control fpfc_checker u_fpfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

FILE: dv/fire_command_checker.sv
`timescale 1ns / 100ps

module fire_command_checker
  import fpfc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire fpfc_in_t              in_data,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire fpfc_out_t             out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         pending,
  output int                         checked_count
);

  fire_sel_t   cur_shoot;
  logic [1:0]  cur_trig;
  logic [15:0] cur_rate;
  logic [7:0]  cur_burst;
  logic [15:0] cur_speed;
  logic [15:0] cur_delay;

  logic        armed;
  logic        armed_changed;
  logic        burst_sent;
  logic        cycle_over;
  logic        gathering;
  logic [31:0] window_open_ms;
  logic [7:0]  shot_tally;

  fpfc_out_t expected_cmds[$];
  fpfc_out_t want;

  function automatic void update_request(fpfc_in_t t);
    if (cur_trig == TRIG_COMMIT) begin
      armed = t.trigger_level;
      armed_changed = t.trigger_toggled;
    end else if (cur_trig == TRIG_PRESS) begin
      if (t.trigger_rose) begin
        armed = 1'b1;
        armed_changed = 1'b1;
      end
    end
  endfunction

  function automatic fpfc_out_t predict_command(fpfc_in_t t);
    fpfc_out_t   c;
    logic [31:0] elapsed;
    c = '0;
    elapsed = t.now_ms - window_open_ms;
    if (cur_shoot != SHOOT_CACHE) gathering = 1'b0;
    case (cur_shoot)
      SHOOT_FULL_AUTO: begin
        update_request(t);
        if (t.trigger_rose) begin
          c.push_cmd = 1'b1;
          c.push_rate_out = cur_rate;
          c.push_shots = FULL_AUTO_SHOTS;
        end
        if (t.trigger_fell) c.halt_cmd = 1'b1;
      end
      SHOOT_SELECT: begin
        update_request(t);
        if (armed) begin
          if (armed_changed) begin
            armed_changed = 1'b0;
            c.speed_cmd = 1'b1;
            c.speed_out = cur_speed;
          end else if (t.wheel_at_speed && !t.pusher_busy && !burst_sent) begin
            c.push_cmd = 1'b1;
            c.push_rate_out = cur_rate;
            c.push_shots = cur_burst;
            burst_sent = 1'b1;
          end else if (!t.pusher_busy && burst_sent && !cycle_over) begin
            c.speed_cmd = 1'b1;
            armed = 1'b0;
            armed_changed = 1'b1;
            cycle_over = 1'b1;
          end
        end else if (armed_changed) begin
          c.halt_cmd = 1'b1;
          c.speed_cmd = 1'b1;
          burst_sent = 1'b0;
          armed = 1'b0;
          armed_changed = 1'b0;
          cycle_over = 1'b0;
        end
      end
      SHOOT_CACHE: begin
        if (gathering && elapsed > {16'd0, cur_delay}) begin
          if (t.wheel_at_speed && !t.pusher_busy) begin
            if (!burst_sent) begin
              c.push_cmd = 1'b1;
              c.push_rate_out = cur_rate;
              c.push_shots = shot_tally;
              burst_sent = 1'b1;
            end else begin
              gathering = 1'b0;
              burst_sent = 1'b0;
            end
          end
        end else if (t.trigger_rose) begin
          if (gathering) begin
            if (shot_tally != CACHE_SHOTS_MAX) shot_tally = shot_tally + 8'd1;
          end else begin
            window_open_ms = t.now_ms;
            c.speed_cmd = 1'b1;
            c.speed_out = cur_speed;
            shot_tally = 8'd1;
            gathering = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_shoot = SHOOT_NULL;
      cur_trig = TRIG_NULL;
      cur_rate = '0;
      cur_burst = BURST_COUNT_RST;
      cur_speed = '0;
      cur_delay = '0;
      armed = 1'b0;
      armed_changed = 1'b0;
      burst_sent = 1'b0;
      cycle_over = 1'b0;
      gathering = 1'b0;
      window_open_ms = '0;
      shot_tally = '0;
      expected_cmds.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SHOOT_MODE:     cur_shoot = fire_sel_t'(cfg_wdata[1:0]);
          REG_TRIGGER_MODE:   cur_trig = cfg_wdata[1:0];
          REG_PUSHER_RATE:    cur_rate = cfg_wdata[15:0];
          REG_BURST_COUNT:    cur_burst = cfg_wdata[7:0];
          REG_FLYWHEEL_SPEED: cur_speed = cfg_wdata[15:0];
          REG_CACHE_DELAY:    cur_delay = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_cmds.size() == 0) begin
          $error("command transaction with no tick outstanding");
          fail_count++;
        end else begin
          want = expected_cmds.pop_front();
          check_field("push_cmd", 32'(want.push_cmd), 32'(out_data.push_cmd));
          check_field("push_rate_out", 32'(want.push_rate_out), 32'(out_data.push_rate_out));
          check_field("push_shots", 32'(want.push_shots), 32'(out_data.push_shots));
          check_field("halt_cmd", 32'(want.halt_cmd), 32'(out_data.halt_cmd));
          check_field("speed_cmd", 32'(want.speed_cmd), 32'(out_data.speed_cmd));
          check_field("speed_out", 32'(want.speed_out), 32'(out_data.speed_out));
          checked_count++;
        end
      end
      if (in_valid && !in_stall) expected_cmds.push_back(predict_command(in_data));
    end
    pending = expected_cmds.size();
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import fpfc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 200;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  fpfc_in_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  fpfc_out_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int checked_count;
  int ticks_sent;
  int phases;
  int idle_cycles;
  bit calm;
  logic sw_held;
  logic [31:0] clock_ms;

  flywheel_pusher_fire_control DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  fire_command_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned draw_gap();
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic fpfc_in_t make_tick(logic level, logic rose, logic fell, logic toggled,
                                         logic spun_up, logic busy, logic [31:0] now);
    fpfc_in_t t;
    t.trigger_level = level;
    t.trigger_rose = rose;
    t.trigger_fell = fell;
    t.trigger_toggled = toggled;
    t.wheel_at_speed = spun_up;
    t.pusher_busy = busy;
    t.now_ms = now;
    return t;
  endfunction

  // mostly a plausible switch with consistent edges, some pure noise
  function automatic fpfc_in_t random_tick();
    fpfc_in_t t;
    bit flip;
    if ($urandom_range(0, 9) == 0) begin
      t = make_tick(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                    1'($urandom), 1'($urandom), $urandom);
    end else begin
      flip = ($urandom_range(0, 3) == 0);
      clock_ms = clock_ms + 32'($urandom_range(0, 3));
      t = make_tick(sw_held ^ flip, flip && !sw_held, flip && sw_held, flip,
                    $urandom_range(0, 3) != 0, $urandom_range(0, 2) == 0, clock_ms);
      if (flip) sw_held = !sw_held;
    end
    return t;
  endfunction

  task automatic send_tick(fpfc_in_t t);
    int unsigned gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!(in_valid && !in_stall));
    ticks_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic set_config(input logic [15:0] shoot, trig, rate, burst, speed, delay);
    drain();
    write_reg(REG_SHOOT_MODE, shoot);
    write_reg(REG_TRIGGER_MODE, trig);
    write_reg(REG_PUSHER_RATE, rate);
    write_reg(REG_BURST_COUNT, burst);
    write_reg(REG_FLYWHEEL_SPEED, speed);
    write_reg(REG_CACHE_DELAY, delay);
    write_reg(REG_UNUSED, 16'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
    phases++;
  endtask

  initial begin : rx_side
    int unsigned hold;
    out_stall = 1'b0;
    forever begin
      hold = draw_gap();
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no transaction for %0d cycles, %0d commands outstanding", idle_cycles, pending);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] burst_pick;
    logic [15:0] delay_pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    calm = 1'b0;
    sw_held = 1'b0;
    clock_ms = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // null mode after reset ignores everything
    send_tick(make_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0));

    // full auto, unused trigger mode, press and release together
    set_config(16'(SHOOT_FULL_AUTO), 16'(TRIG_SPARE), 16'hFFFF, 16'h00FF, 16'hFFFF, 16'h0000);
    send_tick(make_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 32'd10));
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 32'd11));
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 32'd12));
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd13));

    // select fire, commit trigger: spin up, burst, spin down, release
    set_config(16'(SHOOT_SELECT), 16'(TRIG_COMMIT), 16'h1234, 16'h00FF, 16'hFFFF, 16'h0000);
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 32'd20));
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd21));
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 32'd22));
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd23));
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd24));
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 32'd25));

    // select fire, press trigger
    set_config(16'(SHOOT_SELECT), 16'(TRIG_PRESS), 16'h0000, 16'h0000, 16'h8001, 16'h0000);
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 32'd30));
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd31));
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 32'd32));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd33));

    // cache window across the time wrap, expiry, then leaving cache mode
    set_config(16'(SHOOT_CACHE), 16'(TRIG_NULL), 16'hABCD, 16'h0001, 16'h00FF, 16'd5);
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFE));
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF));
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 32'd3));
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 32'd4));
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 32'd5));
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 32'd6));
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 32'd7));
    set_config(16'(SHOOT_FULL_AUTO), 16'(TRIG_NULL), 16'hABCD, 16'h0001, 16'h00FF, 16'd5);
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd8));
    set_config(16'(SHOOT_CACHE), 16'(TRIG_NULL), 16'hABCD, 16'h0001, 16'h00FF, 16'd5);
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 32'd9));

    // random phases, each shoot mode twice
    for (int p = 0; p < 8; p++) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 4))
        0:       burst_pick = {8'($urandom), 8'h00};
        1:       burst_pick = {8'($urandom), 8'hFF};
        default: burst_pick = 16'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       delay_pick = 16'h0000;
        1:       delay_pick = 16'hFFFF;
        default: delay_pick = 16'($urandom_range(0, 24));
      endcase
      set_config({14'($urandom), 2'(p)}, 16'($urandom), 16'($urandom), burst_pick,
                 16'($urandom), delay_pick);
      clock_ms = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFF0;
      repeat (30) send_tick(random_tick());
    end

    // enough presses in one window to saturate the cache count
    calm = ($urandom_range(0, 1) == 0);
    set_config(16'(SHOOT_CACHE), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 16'hFFFF);
    clock_ms = $urandom;
    repeat (270)
      send_tick(make_tick(1'($urandom), 1'b1, 1'($urandom), 1'($urandom),
                          1'($urandom), 1'($urandom), clock_ms));
    clock_ms = clock_ms + 32'd70000;
    repeat (4)
      send_tick(make_tick(1'b0, 1'($urandom), 1'b0, 1'b0, 1'b1, 1'b0, clock_ms));

    drain();
    repeat (4) @(negedge clk);

    $display("Sent %0d ticks over %0d register settings in all shoot and trigger modes,",
             ticks_sent, phases);
    $display("including time wrap, window expiry and cache count saturation; %0d commands checked",
             checked_count);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
